// ===== rtl/range_rotation_cipher_macros.svh =====
// Assertion macros for the range rotation cipher.
// Needs nothing else; the top level includes this header by name.
`ifndef RANGE_ROTATION_CIPHER_MACROS_SVH
`define RANGE_ROTATION_CIPHER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define RRC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("range rotation cipher: same-cycle check failed");

// Antecedent implies consequent in the following cycle.
`define RRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("range rotation cipher: next-cycle check failed");

`endif

// ===== rtl/rrc_pkg.sv =====
// Shared types and constants for the range rotation cipher.
// Depends on nothing; the top level imports it.
package rrc_pkg;

	localparam int CHAR_W     = 8;
	localparam int LEN_W      = CHAR_W + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int COUNT_W    = 3;
	localparam int NUM_RANGES = 4;
	localparam int MAX_RANGES = 4;
	localparam int ACTIVE_LIMIT = (MAX_RANGES < NUM_RANGES) ? MAX_RANGES : NUM_RANGES;
	localparam int STEP_W     = $clog2(CHAR_W);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHIFT    = 3'd0,
		REG_DECIPHER = 3'd1,
		REG_COUNT    = 3'd2,
		REG_RANGE0   = 3'd3,
		REG_RANGE1   = 3'd4,
		REG_RANGE2   = 3'd5,
		REG_RANGE3   = 3'd6
	} cfg_reg_t;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [LEN_W-1:0]  len_t;

endpackage

// ===== rtl/range_rotation_cipher.sv =====
// Range rotation cipher: three-stage byte pipeline with a per-range shift reducer.
// Depends on rrc_pkg and range_rotation_cipher_macros.svh.
//
//  Channel   Handshake              Payload
//  input     in_valid / in_ready    char_in   [7:0]
//  output    out_valid / out_ready  char_out  [7:0]
//  config    cfg_valid / cfg_ready  cfg_index [2:0], cfg_data [15:0]
//
// One byte is taken per cycle while the reducer is idle and stage 1 can load.
// Every configuration write restarts the shift reducer, a restoring remainder unit
// with one lane per range that retires one shift bit a cycle, so in_ready stays low
// until every shift bit is retired. Reset clears the key, the valid bits and the
// reduced shifts; the data registers of the pipeline are not reset.
// A stalled output holds each stage in place; bubbles are filled.
`include "range_rotation_cipher_macros.svh"

module range_rotation_cipher
	import rrc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CHAR_W-1:0]     char_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CHAR_W-1:0]     char_out,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers.
	char_t               shift_q;
	logic                decipher_q;
	logic [COUNT_W-1:0]  count_q;
	logic [2*CHAR_W-1:0] range_q [NUM_RANGES];

	// Shift reducer state.
	logic               busy_q;
	logic [STEP_W-1:0]  step_q;
	char_t              red_q [NUM_RANGES];

	// Pipeline registers.
	logic                  v_s1, v_s2, v_s3;
	char_t                 char_s1;
	logic [NUM_RANGES-1:0] hit_s1;
	char_t                 first_s2, off_s2, red_s2;
	len_t                  len_s2;
	logic                  dec_s2;
	char_t                 char_s3;

	logic  cfg_wr;
	logic  in_acc;
	logic  rdy1, rdy2, rdy3;
	char_t first_w [NUM_RANGES];
	char_t last_w  [NUM_RANGES];
	len_t  len_w   [NUM_RANGES];

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// Configuration writes; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q    <= '0;
			decipher_q <= 1'b0;
			count_q    <= '0;
			for (int i = 0; i < NUM_RANGES; i++) begin
				range_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_SHIFT:    shift_q    <= cfg_data[CHAR_W-1:0];
				REG_DECIPHER: decipher_q <= cfg_data[0];
				REG_COUNT:    count_q    <= cfg_data[COUNT_W-1:0];
				REG_RANGE0:   range_q[0] <= cfg_data;
				REG_RANGE1:   range_q[1] <= cfg_data;
				REG_RANGE2:   range_q[2] <= cfg_data;
				REG_RANGE3:   range_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Range bounds and lengths; a reversed range gets a meaningless length.
	always_comb begin
		for (int i = 0; i < NUM_RANGES; i++) begin
			first_w[i] = range_q[i][CHAR_W-1:0];
			last_w[i]  = range_q[i][2*CHAR_W-1:CHAR_W];
			len_w[i]   = {1'b0, last_w[i]} - {1'b0, first_w[i]} + LEN_W'(1);
		end
	end

	// Shift reducer: restoring remainder of the shift by each range length,
	// one shift bit per cycle from the top bit down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			for (int i = 0; i < NUM_RANGES; i++) begin
				red_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(CHAR_W - 1);
			for (int i = 0; i < NUM_RANGES; i++) begin
				red_q[i] <= '0;
			end
		end else if (busy_q) begin
			for (int i = 0; i < NUM_RANGES; i++) begin
				if ({red_q[i], shift_q[step_q]} >= len_w[i]) begin
					red_q[i] <= CHAR_W'({red_q[i], shift_q[step_q]} - len_w[i]);
				end else begin
					red_q[i] <= {red_q[i][CHAR_W-2:0], shift_q[step_q]};
				end
			end
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end
			step_q <= step_q - STEP_W'(1);
		end
	end

	// Stage flow control: a stage loads when it is empty or its successor moves.
	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1 && !busy_q;
	assign in_acc   = in_valid && in_ready;

	// Stage 1: range hit test for every active lane.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			char_s1 <= char_in;
			for (int i = 0; i < NUM_RANGES; i++) begin
				hit_s1[i] <= (COUNT_W'(i) < count_q) && (i < ACTIVE_LIMIT)
					&& (last_w[i] >= first_w[i])
					&& (char_in >= first_w[i]) && (char_in <= last_w[i]);
			end
		end
	end

	// Stage 2: first hitting range wins; a miss becomes a length-one range at the byte.
	char_t sel_first, sel_off, sel_red;
	len_t  sel_len;

	always_comb begin
		sel_first = char_s1;
		sel_off   = '0;
		sel_red   = '0;
		sel_len   = LEN_W'(1);
		for (int i = NUM_RANGES - 1; i >= 0; i--) begin
			if (hit_s1[i]) begin
				sel_first = first_w[i];
				sel_off   = char_s1 - first_w[i];
				sel_red   = red_q[i];
				sel_len   = len_w[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy2) begin
			first_s2 <= sel_first;
			off_s2   <= sel_off;
			red_s2   <= sel_red;
			len_s2   <= sel_len;
			dec_s2   <= decipher_q;
		end
	end

	// Stage 3: rotate the offset within the range and add the range start back.
	len_t fwd_sum, new_off;

	always_comb begin
		fwd_sum = {1'b0, off_s2} + {1'b0, red_s2};
		if (dec_s2) begin
			if (off_s2 >= red_s2) begin
				new_off = {1'b0, off_s2 - red_s2};
			end else begin
				new_off = {1'b0, off_s2} + len_s2 - {1'b0, red_s2};
			end
		end else if (fwd_sum >= len_s2) begin
			new_off = fwd_sum - len_s2;
		end else begin
			new_off = fwd_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy3) begin
			char_s3 <= first_s2 + new_off[CHAR_W-1:0];
		end
	end

	assign out_valid = v_s3;
	assign char_out  = char_s3;

	// Checks on the reducer and the input gate.
	`RRC_ASSERT_SAME(a_busy_blocks_input, clk, arst_n, busy_q, !in_ready)
	`RRC_ASSERT_NEXT(a_write_starts_reducer, clk, arst_n, cfg_wr, busy_q && step_q == STEP_W'(CHAR_W - 1))
	`RRC_ASSERT_NEXT(a_reducer_finishes, clk, arst_n, busy_q && step_q == '0 && !cfg_wr, !busy_q)

endmodule
